FILE: rtl/core/psp_pkg.sv
// Package: field widths, prefix table and scan stage codes for the sentence parser.
package psp_pkg;

   localparam int RX_BYTE_W  = 8;
   localparam int TIME_W     = 32;
   localparam int ACCUM_W    = 32;
   localparam int DISTANCE_W = 16;
   localparam int ENERGY_W   = 8;
   localparam int PREFIX_LEN = 6;
   localparam int FIELD_MAX  = 5;

   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_VT    = 8'd11;
   localparam logic [7:0] CHAR_FF    = 8'd12;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_F     = 8'h46;
   localparam logic [7:0] CHAR_N     = 8'h4E;
   localparam logic [7:0] CHAR_O     = 8'h4F;

   // 0..6 matched, 7 marks a mismatch
   localparam logic [2:0] PREFIX_BAD = 3'd7;

   typedef enum logic [1:0] {
      STG_COMMA  = 2'd0,
      STG_BLANK  = 2'd1,
      STG_SIGN   = 2'd2,
      STG_DIGITS = 2'd3
   } conv_stage_type;

   typedef enum logic {
      FORM_NUMERIC = 1'b0,
      FORM_ON_OFF  = 1'b1
   } frame_form_type;

   // "$JYBSS"
   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0:    ch = 8'h24;
         3'd1:    ch = 8'h4A;
         3'd2:    ch = 8'h59;
         3'd3:    ch = 8'h42;
         3'd4:    ch = 8'h53;
         3'd5:    ch = 8'h53;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: rtl/core/psp_if.sv
// Channel interfaces: received byte beats in, parsed frame beats out.
interface psp_req_if import psp_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [RX_BYTE_W-1:0] rx_byte;
   logic [TIME_W-1:0]    now_ms;

   modport source (output valid, rx_byte, now_ms, input ready);
   modport sink   (input valid, rx_byte, now_ms, output ready);
endinterface

interface psp_rsp_if import psp_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic                  present;
   logic                  moving;
   logic [DISTANCE_W-1:0] range_cm;
   logic [ENERGY_W-1:0]   move_energy;
   logic [ENERGY_W-1:0]   still_energy;
   logic [TIME_W-1:0]     stamp_ms;
   logic                  frame_form;

   modport source (output valid, present, moving, range_cm, move_energy,
                   still_energy, stamp_ms, frame_form, input ready);
   modport sink   (input valid, present, moving, range_cm, move_energy,
                   still_energy, stamp_ms, frame_form, output ready);
endinterface

FILE: rtl/core/presence_sentence_parser_core.sv
// Presence sensor sentence parser: byte stream in, one frame beat per committed line.
//
// Each req beat carries one received byte and the current time. Lines end on
// CR, LF or NUL; empty lines vanish. A line starting with "$JYBSS" is scanned
// as ",%d,%d,%d,%d,%d" (blanks and a sign allowed, values wrap mod 2^32).
// Three or more fields commit a numeric frame (frame_form 0); otherwise a $JYBSS line
// holding ON or OFF commits an ON/OFF frame (frame_form 1, ON wins) that only
// changes present and the stamp. Every rsp beat carries the full held record.
// Rate: one byte per clock unless the result is held back. The whole per-byte update
// (prefix match, a x10 shift-add into the field accumulator, line-end commit) is
// combinational between the line state and the result register, so a byte is taken
// in every cycle in which the result register is empty or being drained.
// A result appears in the cycle after the terminating byte's beat. No clearing
// pass after reset.
module presence_sentence_parser_core
   import psp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   psp_req_if.sink        req_chan,
   psp_rsp_if.source      rsp_chan
);

   // ---- line state ----
   logic [2:0]            prefix_pos_ff, prefix_pos_in;
   logic                  line_active_ff, line_active_in;
   logic                  prefix_ok_ff, prefix_ok_in;
   logic                  scan_stop_ff, scan_stop_in;
   logic [2:0]            conv_count_ff, conv_count_in;
   conv_stage_type        conv_stage_ff, conv_stage_in;
   logic                  negative_ff, negative_in;
   logic [ACCUM_W-1:0]    accum_ff, accum_in;
   logic                  cap_presence_one_ff, cap_presence_one_in;
   logic                  cap_motion_one_ff, cap_motion_one_in;
   logic [DISTANCE_W-1:0] cap_distance_ff, cap_distance_in;
   logic [ENERGY_W-1:0]   cap_move_energy_ff, cap_move_energy_in;
   logic [ENERGY_W-1:0]   cap_still_energy_ff, cap_still_energy_in;
   logic [7:0]            prev_char_ff, prev_char_in;
   logic [7:0]            prev2_char_ff, prev2_char_in;
   logic                  saw_on_ff, saw_on_in;
   logic                  saw_off_ff, saw_off_in;

   // ---- held record, doubles as the result register ----
   logic                  held_present_ff, held_present_in;
   logic                  held_moving_ff, held_moving_in;
   logic [DISTANCE_W-1:0] held_distance_ff, held_distance_in;
   logic [ENERGY_W-1:0]   held_move_energy_ff, held_move_energy_in;
   logic [ENERGY_W-1:0]   held_still_energy_ff, held_still_energy_in;
   logic [TIME_W-1:0]     held_stamp_ff, held_stamp_in;
   frame_form_type        frame_form_ff, frame_form_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  req_take;
   logic [7:0]            rx_char;
   logic                  is_eol, is_digit, is_blank;
   logic [3:0]            digit_val;

   // field value as it would close now
   logic                  fin_one;
   logic [DISTANCE_W-1:0] fin_low;
   logic                  fcap_presence_one, fcap_motion_one;
   logic [DISTANCE_W-1:0] fcap_distance;
   logic [ENERGY_W-1:0]   fcap_move_energy, fcap_still_energy;
   logic [2:0]            fcount;
   logic                  eol_finish;
   logic [2:0]            eol_count;

   // Result register is freed when it is empty or drained this cycle, so the
   // next byte never waits on a bubble.
   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign req_take       = req_chan.valid & req_chan.ready;

   assign rx_char   = req_chan.rx_byte;
   assign is_eol    = (rx_char == CHAR_CR) || (rx_char == CHAR_LF) || (rx_char == CHAR_NUL);
   assign is_digit  = (rx_char >= CHAR_ZERO) && (rx_char <= CHAR_NINE);
   assign is_blank  = (rx_char == CHAR_SPACE) || (rx_char == CHAR_TAB) ||
                      (rx_char == CHAR_VT) || (rx_char == CHAR_FF) || (rx_char == CHAR_CR);
   assign digit_val = rx_char[3:0];

   // Wrapped value is one: +1, or magnitude all ones when negated.
   assign fin_one = negative_ff ? (accum_ff == {ACCUM_W{1'b1}})
                                : (accum_ff == ACCUM_W'(1));
   assign fin_low = negative_ff ? (DISTANCE_W'(0) - accum_ff[DISTANCE_W-1:0])
                                : accum_ff[DISTANCE_W-1:0];
   assign fcount  = conv_count_ff + 3'd1;

   // Captures with the open field closed into its slot.
   always_comb begin
      fcap_presence_one = cap_presence_one_ff;
      fcap_motion_one   = cap_motion_one_ff;
      fcap_distance     = cap_distance_ff;
      fcap_move_energy  = cap_move_energy_ff;
      fcap_still_energy = cap_still_energy_ff;
      unique case (conv_count_ff)
         3'd0:    fcap_presence_one = fin_one;
         3'd1:    fcap_motion_one   = fin_one;
         3'd2:    fcap_distance     = fin_low;
         3'd3:    fcap_move_energy  = fin_low[ENERGY_W-1:0];
         default: fcap_still_energy = fin_low[ENERGY_W-1:0];
      endcase
   end

   assign eol_finish = prefix_ok_ff & ~scan_stop_ff & (conv_stage_ff == STG_DIGITS) &
                       (conv_count_ff < 3'(FIELD_MAX));
   assign eol_count  = eol_finish ? fcount : conv_count_ff;

   always_comb begin
      prefix_pos_in        = prefix_pos_ff;
      line_active_in       = line_active_ff;
      prefix_ok_in         = prefix_ok_ff;
      scan_stop_in         = scan_stop_ff;
      conv_count_in        = conv_count_ff;
      conv_stage_in        = conv_stage_ff;
      negative_in          = negative_ff;
      accum_in             = accum_ff;
      cap_presence_one_in  = cap_presence_one_ff;
      cap_motion_one_in    = cap_motion_one_ff;
      cap_distance_in      = cap_distance_ff;
      cap_move_energy_in   = cap_move_energy_ff;
      cap_still_energy_in  = cap_still_energy_ff;
      prev_char_in         = prev_char_ff;
      prev2_char_in        = prev2_char_ff;
      saw_on_in            = saw_on_ff;
      saw_off_in           = saw_off_ff;
      held_present_in      = held_present_ff;
      held_moving_in       = held_moving_ff;
      held_distance_in     = held_distance_ff;
      held_move_energy_in  = held_move_energy_ff;
      held_still_energy_in = held_still_energy_ff;
      held_stamp_in        = held_stamp_ff;
      frame_form_in        = frame_form_ff;
      rsp_valid_in         = rsp_valid_ff & ~rsp_chan.ready;

      if (req_take) begin
         if (is_eol) begin
            if (line_active_ff) begin
               if (eol_count >= 3'd3) begin
                  // numeric frame; open field folded in if it was still running
                  held_present_in      = eol_finish ? fcap_presence_one : cap_presence_one_ff;
                  held_moving_in       = eol_finish ? fcap_motion_one : cap_motion_one_ff;
                  held_distance_in     = eol_finish ? fcap_distance : cap_distance_ff;
                  held_move_energy_in  = (eol_count < 3'd4) ? ENERGY_W'(0) :
                                         (eol_finish ? fcap_move_energy
                                                     : cap_move_energy_ff);
                  held_still_energy_in = (eol_count < 3'd5) ? ENERGY_W'(0) :
                                         (eol_finish ? fcap_still_energy
                                                     : cap_still_energy_ff);
                  held_stamp_in        = req_chan.now_ms;
                  frame_form_in        = FORM_NUMERIC;
                  rsp_valid_in         = 1'b1;
               end else if (prefix_ok_ff && (saw_on_ff || saw_off_ff)) begin
                  held_present_in = saw_on_ff;
                  held_stamp_in   = req_chan.now_ms;
                  frame_form_in   = FORM_ON_OFF;
                  rsp_valid_in    = 1'b1;
               end
               // start a fresh line
               prefix_pos_in       = 3'd0;
               line_active_in      = 1'b0;
               prefix_ok_in        = 1'b0;
               scan_stop_in        = 1'b0;
               conv_count_in       = 3'd0;
               conv_stage_in       = STG_COMMA;
               negative_in         = 1'b0;
               accum_in            = '0;
               cap_presence_one_in = 1'b0;
               cap_motion_one_in   = 1'b0;
               cap_distance_in     = '0;
               cap_move_energy_in  = '0;
               cap_still_energy_in = '0;
               prev_char_in        = '0;
               prev2_char_in       = '0;
               saw_on_in           = 1'b0;
               saw_off_in          = 1'b0;
            end
         end else begin
            line_active_in = 1'b1;
            if (prev_char_ff == CHAR_O && rx_char == CHAR_N) begin
               saw_on_in = 1'b1;
            end
            if (prev2_char_ff == CHAR_O && prev_char_ff == CHAR_F && rx_char == CHAR_F) begin
               saw_off_in = 1'b1;
            end
            prev2_char_in = prev_char_ff;
            prev_char_in  = rx_char;

            if (!prefix_ok_ff) begin
               if (prefix_pos_ff < 3'(PREFIX_LEN) && rx_char == prefix_char(prefix_pos_ff)) begin
                  prefix_pos_in = prefix_pos_ff + 3'd1;
                  if (prefix_pos_ff == 3'(PREFIX_LEN - 1)) begin
                     prefix_ok_in  = 1'b1;
                     conv_stage_in = STG_COMMA;
                  end
               end else begin
                  prefix_pos_in = PREFIX_BAD;
               end
            end else if (!scan_stop_ff && conv_count_ff < 3'(FIELD_MAX)) begin
               unique case (conv_stage_ff)
                  STG_DIGITS: begin
                     if (is_digit) begin
                        // x*10 + d as two shifts and an add
                        accum_in = {accum_ff[ACCUM_W-4:0], 3'b000} +
                                   {accum_ff[ACCUM_W-2:0], 1'b0} +
                                   ACCUM_W'(digit_val);
                     end else begin
                        // close field, then treat this byte as the separator
                        cap_presence_one_in = fcap_presence_one;
                        cap_motion_one_in   = fcap_motion_one;
                        cap_distance_in     = fcap_distance;
                        cap_move_energy_in  = fcap_move_energy;
                        cap_still_energy_in = fcap_still_energy;
                        conv_count_in       = fcount;
                        conv_stage_in       = STG_COMMA;
                        if (fcount >= 3'(FIELD_MAX)) begin
                           scan_stop_in = 1'b1;
                        end else if (rx_char == CHAR_COMMA) begin
                           conv_stage_in = STG_BLANK;
                        end else begin
                           scan_stop_in = 1'b1;
                        end
                     end
                  end
                  STG_COMMA: begin
                     if (rx_char == CHAR_COMMA) begin
                        conv_stage_in = STG_BLANK;
                     end else begin
                        scan_stop_in = 1'b1;
                     end
                  end
                  STG_BLANK: begin
                     priority if (is_blank) begin
                        conv_stage_in = STG_BLANK;
                     end else if (rx_char == CHAR_PLUS || rx_char == CHAR_MINUS) begin
                        negative_in   = (rx_char == CHAR_MINUS);
                        conv_stage_in = STG_SIGN;
                     end else if (is_digit) begin
                        negative_in   = 1'b0;
                        accum_in      = ACCUM_W'(digit_val);
                        conv_stage_in = STG_DIGITS;
                     end else begin
                        scan_stop_in = 1'b1;
                     end
                  end
                  STG_SIGN: begin
                     if (is_digit) begin
                        accum_in      = ACCUM_W'(digit_val);
                        conv_stage_in = STG_DIGITS;
                     end else begin
                        scan_stop_in = 1'b1;
                     end
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_pos_ff        <= 3'd0;
         line_active_ff       <= 1'b0;
         prefix_ok_ff         <= 1'b0;
         scan_stop_ff         <= 1'b0;
         conv_count_ff        <= 3'd0;
         conv_stage_ff        <= STG_COMMA;
         negative_ff          <= 1'b0;
         accum_ff             <= '0;
         cap_presence_one_ff  <= 1'b0;
         cap_motion_one_ff    <= 1'b0;
         cap_distance_ff      <= '0;
         cap_move_energy_ff   <= '0;
         cap_still_energy_ff  <= '0;
         prev_char_ff         <= '0;
         prev2_char_ff        <= '0;
         saw_on_ff            <= 1'b0;
         saw_off_ff           <= 1'b0;
         held_present_ff      <= 1'b0;
         held_moving_ff       <= 1'b0;
         held_distance_ff     <= '0;
         held_move_energy_ff  <= '0;
         held_still_energy_ff <= '0;
         held_stamp_ff        <= '0;
         frame_form_ff        <= FORM_NUMERIC;
         rsp_valid_ff         <= 1'b0;
      end else begin
         prefix_pos_ff        <= prefix_pos_in;
         line_active_ff       <= line_active_in;
         prefix_ok_ff         <= prefix_ok_in;
         scan_stop_ff         <= scan_stop_in;
         conv_count_ff        <= conv_count_in;
         conv_stage_ff        <= conv_stage_in;
         negative_ff          <= negative_in;
         accum_ff             <= accum_in;
         cap_presence_one_ff  <= cap_presence_one_in;
         cap_motion_one_ff    <= cap_motion_one_in;
         cap_distance_ff      <= cap_distance_in;
         cap_move_energy_ff   <= cap_move_energy_in;
         cap_still_energy_ff  <= cap_still_energy_in;
         prev_char_ff         <= prev_char_in;
         prev2_char_ff        <= prev2_char_in;
         saw_on_ff            <= saw_on_in;
         saw_off_ff           <= saw_off_in;
         held_present_ff      <= held_present_in;
         held_moving_ff       <= held_moving_in;
         held_distance_ff     <= held_distance_in;
         held_move_energy_ff  <= held_move_energy_in;
         held_still_energy_ff <= held_still_energy_in;
         held_stamp_ff        <= held_stamp_in;
         frame_form_ff        <= frame_form_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.present      = held_present_ff;
   assign rsp_chan.moving       = held_moving_ff;
   assign rsp_chan.range_cm     = held_distance_ff;
   assign rsp_chan.move_energy  = held_move_energy_ff;
   assign rsp_chan.still_energy = held_still_energy_ff;
   assign rsp_chan.stamp_ms     = held_stamp_ff;
   assign rsp_chan.frame_form   = frame_form_ff;

endmodule
